// File: rtl/assert_macros.svh
// Assertion helpers used by the point iterator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every clock, ignored during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/ifs_pkg.sv
// ----------------------------------------------------------------------------
// ifs_pkg
// Shared constants and types of the chaos-game point iterator.
// ----------------------------------------------------------------------------
package ifs_pkg;

   localparam int MaxTransformsDefault = 8;
   localparam int CoefSlots            = 9;
   localparam int ValueWidth           = 32;
   localparam int PixelWidth           = 12;
   localparam int SizeWidth            = 13;

   localparam logic [1:0] FuncLoad    = 2'd0;
   localparam logic [1:0] FuncStart   = 2'd1;
   localparam logic [1:0] FuncIterate = 2'd2;

   localparam logic [3:0] SlotProb = 4'd9;

   localparam logic [1:0] CsrTransformCount = 2'd0;
   localparam logic [1:0] CsrIterationCount = 2'd1;
   localparam logic [1:0] CsrImageWidth     = 2'd2;
   localparam logic [1:0] CsrImageHeight    = 2'd3;

   localparam logic signed [31:0] OneQ16 = 32'sh0001_0000;

   // Request handed from the controller to the divider.
   typedef struct packed {
      logic               start;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [12:0]        width;
      logic [12:0]        height;
   } div_req_type;

endpackage

// File: rtl/ifs_coef_mem.sv
// ----------------------------------------------------------------------------
// ifs_coef_mem
// Synchronous coefficient and probability store, one read port, one write port.
// ----------------------------------------------------------------------------
module ifs_coef_mem import ifs_pkg::*; #(
   parameter int Depth = MaxTransformsDefault * 10
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(Depth)-1:0]     wr_addr,
   input  logic signed [ValueWidth-1:0] wr_data,
   input  logic [$clog2(Depth)-1:0]     rd_addr,
   output logic signed [ValueWidth-1:0] rd_data
);

   logic signed [ValueWidth-1:0] mem_ff [Depth];
   logic signed [ValueWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ifs_divider.sv
// ----------------------------------------------------------------------------
// ifs_divider
// Bit-serial signed divider that scales both coordinates to pixels.
// ----------------------------------------------------------------------------
module ifs_divider import ifs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  div_req_type           req,
   output logic                  busy,
   output logic                  done,
   output logic [PixelWidth-1:0] pix_x,
   output logic [PixelWidth-1:0] pix_y,
   output logic                  ok
);

   typedef enum logic [2:0] {
      S_IDLE, S_MULX, S_DIVX, S_MULY, S_DIVY, S_DONE
   } state_type;

   state_type   state_ff;
   logic [5:0]  cnt_ff;
   logic [44:0] num_ff;
   logic [44:0] quo_ff;
   logic [45:0] rem_ff;
   logic [31:0] den_ff;
   logic        neg_ff;
   logic        ok_ff;
   logic signed [31:0] y_ff;
   logic signed [31:0] z_ff;
   logic [12:0] w_ff;
   logic [12:0] h_ff;
   logic [PixelWidth-1:0] px_ff;
   logic [PixelWidth-1:0] py_ff;

   logic signed [45:0] prod_in;
   logic [45:0] trial_in;
   logic [45:0] rem_sh_in;
   logic signed [46:0] q_signed_in;
   logic        q_ok_in;
   logic [12:0] size_sel;

   assign size_sel  = (state_ff == S_DIVX) ? w_ff : h_ff;
   assign rem_sh_in = {rem_ff[44:0], num_ff[44]};
   assign trial_in  = rem_sh_in - {14'd0, den_ff};

   always_comb begin
      prod_in = (state_ff == S_MULX) ? (req.x * $signed({1'b0, w_ff}))
                                     : (y_ff * $signed({1'b0, h_ff}));
      q_signed_in = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
      q_ok_in = !q_signed_in[46] && (q_signed_in < $signed({34'd0, size_sel}))
                && (q_signed_in <= 47'sd4095);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req.start) begin
                  w_ff  <= req.width;
                  h_ff  <= req.height;
                  y_ff  <= req.y;
                  z_ff  <= req.z;
                  ok_ff <= (req.z != 0);
                  state_ff <= S_MULX;
               end
            end
            S_MULX, S_MULY: begin
               num_ff <= prod_in[45] ? 45'(-prod_in) : prod_in[44:0];
               den_ff <= z_ff[31] ? 32'(-z_ff) : z_ff;
               neg_ff <= prod_in[45] ^ z_ff[31];
               rem_ff <= '0;
               quo_ff <= '0;
               cnt_ff <= 6'd45;
               state_ff <= (state_ff == S_MULX) ? S_DIVX : S_DIVY;
            end
            S_DIVX, S_DIVY: begin
               if (cnt_ff != 0) begin
                  num_ff <= {num_ff[43:0], 1'b0};
                  if (!trial_in[45] && rem_sh_in >= {14'd0, den_ff}) begin
                     rem_ff <= trial_in;
                     quo_ff <= {quo_ff[43:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh_in;
                     quo_ff <= {quo_ff[43:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff - 6'd1;
               end else begin
                  ok_ff <= ok_ff && q_ok_in;
                  if (state_ff == S_DIVX) begin
                     px_ff <= quo_ff[PixelWidth-1:0];
                     state_ff <= S_MULY;
                  end else begin
                     py_ff <= quo_ff[PixelWidth-1:0];
                     state_ff <= S_DONE;
                  end
               end
            end
            S_DONE:  state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // The x product is taken straight from the request, held by the controller.
   assign busy  = (state_ff != S_IDLE) || req.start;
   assign done  = (state_ff == S_DONE);
   assign ok    = ok_ff;
   assign pix_x = ok_ff ? px_ff : '0;
   assign pix_y = ok_ff ? py_ff : '0;

endmodule

// File: rtl/ifs_chaos_game_point_iterator.sv
// ----------------------------------------------------------------------------
// ifs_chaos_game_point_iterator
// Chaos-game iterator for an iterated function system.
// ----------------------------------------------------------------------------
// Load and start requests are handled in the idle state and do not hold off
// the next request. An iterate request walks the probabilities through the
// registered table memory (with the count held between 1 and MaxTransforms),
// then reads the nine coefficients from the same port and accumulates one
// product per cycle, taking no new request until done; an iterate past the
// iteration count is taken and ignored. The finishing iterate runs the
// bit-serial divider, which produces both pixel coordinates in turn, and
// loads the result register, which frees the block to accept the next
// request while a pixel waits to be taken; a later pixel waits for it to go.
module ifs_chaos_game_point_iterator import ifs_pkg::*; #(
   parameter int MaxTransforms = MaxTransformsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_func,
   input  logic [2:0]            req_entry_index,
   input  logic [3:0]            req_slot,
   input  logic signed [31:0]    req_table_value,
   input  logic [15:0]           req_point_x,
   input  logic [15:0]           req_point_y,
   input  logic [15:0]           req_chooser,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PixelWidth-1:0] rsp_pixel_x,
   output logic [PixelWidth-1:0] rsp_pixel_y,
   output logic                  rsp_in_range,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data
);

`include "assert_macros.svh"

   // Entries 0..MaxTransforms*9-1 hold coefficients, the rest probabilities.
   localparam int Depth = MaxTransforms * 10;
   localparam int AW    = $clog2(Depth);
   localparam int TW    = (MaxTransforms > 1) ? $clog2(MaxTransforms) : 1;
   localparam int CW    = $clog2(MaxTransforms + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_PICK, S_MAC, S_DIVIDE, S_OUT
   } state_type;

   state_type state_ff;
   logic [3:0]  tcount_ff;
   logic [15:0] iters_ff;
   logic [12:0] width_ff;
   logic [12:0] height_ff;
   logic signed [31:0] x_ff, y_ff, z_ff;
   logic signed [31:0] nx_ff, ny_ff;
   logic [15:0] steps_ff;
   logic [15:0] chooser_ff;
   logic [TW-1:0] pick_ff;
   logic          pick_found_ff;
   logic [CW-1:0] pidx_ff;
   logic signed [35:0] psum_ff;
   logic [3:0]  k_ff;
   logic [3:0]  kr_ff;
   logic        kr_live_ff;
   logic signed [63:0] prod_ff;
   logic        prod_live_ff;
   logic [3:0]  prod_k_ff;
   logic signed [50:0] hi_ff;
   logic [17:0] lo_ff;
   logic        rsp_valid_ff;
   logic [PixelWidth-1:0] rsp_x_ff, rsp_y_ff;
   logic        rsp_ok_ff;
   div_req_type div_req_ff;

   logic [CW-1:0] ntrans;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic signed [31:0] mem_rdata;
   logic          load_ok;
   logic          acc;
   logic          rsp_load;
   logic          prod_first;
   logic signed [35:0] psum_in;
   logic signed [47:0] h_in;
   logic signed [50:0] hi_in;
   logic [17:0] lo_in;
   logic signed [51:0] row_in;
   logic signed [31:0] sat_in;
   logic        div_busy, div_done, div_ok;
   logic [PixelWidth-1:0] div_x, div_y;

   always_comb begin
      if (tcount_ff == 0) ntrans = CW'(1);
      else if (32'(tcount_ff) > MaxTransforms) ntrans = CW'(MaxTransforms);
      else ntrans = CW'(tcount_ff);
   end

   assign acc     = req_valid && !req_stall;
   assign load_ok = (32'(req_entry_index) < MaxTransforms) && (req_slot <= SlotProb);
   assign mem_we  = acc && (req_func == FuncLoad) && load_ok;
   assign mem_waddr = (req_slot == SlotProb)
                      ? AW'(MaxTransforms * CoefSlots + 32'(req_entry_index))
                      : AW'(32'(req_entry_index) * CoefSlots + 32'(req_slot));

   always_comb begin
      if (state_ff == S_PICK) mem_raddr = AW'(MaxTransforms * CoefSlots + 32'(pidx_ff));
      else mem_raddr = AW'(32'(pick_ff) * CoefSlots + 32'(k_ff));
   end

   ifs_coef_mem #(.Depth(Depth)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (req_table_value),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   ifs_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req_ff),
      .busy  (div_busy),
      .done  (div_done),
      .pix_x (div_x),
      .pix_y (div_y),
      .ok    (div_ok)
   );

   assign psum_in = psum_ff + 36'(mem_rdata);

   // The first product of each matrix row restarts the row sum.
   assign prod_first = (prod_k_ff inside {4'd0, 4'd3, 4'd6});

   // floor(p/65536) and the low 16 bits; the low parts are summed exactly.
   assign h_in   = prod_ff[63:16];
   assign hi_in  = prod_first ? 51'(h_in) : hi_ff + 51'(h_in);
   assign lo_in  = prod_first ? {2'b00, prod_ff[15:0]}
                              : lo_ff + {2'b00, prod_ff[15:0]};
   assign row_in = 52'(hi_in) + 52'(lo_in[17:16]);
   assign sat_in = (row_in > 52'sd2147483647)  ? 32'sh7FFF_FFFF :
                   (row_in < -52'sd2147483648) ? 32'sh8000_0000 : 32'(row_in);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tcount_ff    <= 4'd1;
         iters_ff     <= 16'd1;
         width_ff     <= 13'd256;
         height_ff    <= 13'd256;
         x_ff         <= '0;
         y_ff         <= '0;
         z_ff         <= OneQ16;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         div_req_ff.start <= 1'b0;
         kr_live_ff   <= 1'b0;
         prod_live_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CsrTransformCount: tcount_ff <= csr_data[3:0];
               CsrIterationCount: iters_ff  <= csr_data;
               CsrImageWidth:     width_ff  <= csr_data[12:0];
               CsrImageHeight:    height_ff <= csr_data[12:0];
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_x_ff     <= div_x;
            rsp_y_ff     <= div_y;
            rsp_ok_ff    <= div_ok;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (acc && req_func == FuncStart) begin
                  x_ff     <= 32'(req_point_x);
                  y_ff     <= 32'(req_point_y);
                  z_ff     <= OneQ16;
                  steps_ff <= '0;
               end else if (acc && req_func == FuncIterate && steps_ff < iters_ff) begin
                  chooser_ff    <= req_chooser;
                  pidx_ff       <= '0;
                  psum_ff       <= '0;
                  pick_found_ff <= 1'b0;
                  state_ff      <= S_PICK;
               end
            end
            S_PICK: begin
               // Issue one probability read per cycle and consume it in the next.
               pidx_ff <= pidx_ff + CW'(1);
               if (pidx_ff != 0) begin
                  psum_ff <= psum_in;
                  if (!pick_found_ff && psum_in > $signed({20'd0, chooser_ff})) begin
                     pick_found_ff <= 1'b1;
                     pick_ff       <= TW'(pidx_ff - CW'(1));
                  end else if (!pick_found_ff) begin
                     pick_ff <= TW'(pidx_ff - CW'(1));
                  end
                  if (pidx_ff == ntrans) begin
                     k_ff       <= '0;
                     kr_live_ff <= 1'b0;
                     prod_live_ff <= 1'b0;
                     state_ff   <= S_MAC;
                  end
               end
            end
            S_MAC: begin
               // Read, multiply, accumulate: one coefficient a cycle.
               kr_ff      <= k_ff;
               kr_live_ff <= (k_ff < 4'(CoefSlots));
               if (k_ff < 4'(CoefSlots)) k_ff <= k_ff + 4'd1;
               prod_live_ff <= kr_live_ff;
               prod_k_ff    <= kr_ff;
               if (kr_live_ff) begin
                  if (kr_ff inside {4'd0, 4'd3, 4'd6}) prod_ff <= mem_rdata * x_ff;
                  else if (kr_ff inside {4'd1, 4'd4, 4'd7}) prod_ff <= mem_rdata * y_ff;
                  else prod_ff <= mem_rdata * z_ff;
               end
               if (prod_live_ff) begin
                  hi_ff <= hi_in;
                  lo_ff <= lo_in;
                  if (prod_k_ff == 4'd2) nx_ff <= sat_in;
                  if (prod_k_ff == 4'd5) ny_ff <= sat_in;
                  if (prod_k_ff == 4'd8) begin
                     x_ff     <= nx_ff;
                     y_ff     <= ny_ff;
                     z_ff     <= sat_in;
                     steps_ff <= steps_ff + 16'd1;
                     if (steps_ff + 16'd1 == iters_ff) begin
                        div_req_ff.start  <= 1'b1;
                        div_req_ff.x      <= nx_ff;
                        div_req_ff.y      <= ny_ff;
                        div_req_ff.z      <= sat_in;
                        div_req_ff.width  <= width_ff;
                        div_req_ff.height <= height_ff;
                        state_ff <= S_DIVIDE;
                     end else begin
                        state_ff <= S_IDLE;
                     end
                  end
               end
            end
            S_DIVIDE: begin
               div_req_ff.start <= 1'b0;
               if (div_done) state_ff <= S_OUT;
            end
            S_OUT: begin
               // Waits here while the previous pixel is still held.
               if (rsp_load) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pixel_x  = rsp_x_ff;
   assign rsp_pixel_y  = rsp_y_ff;
   assign rsp_in_range = rsp_ok_ff;

   `ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != S_IDLE, req_stall,
      "request accepted while an iterate is in flight")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_in_range), "stalled result changed")
   `ASSERT_IMPL(a_div_only_divide, clock, reset, div_busy && !div_req_ff.start,
      state_ff == S_DIVIDE, "divider running outside the divide phase")
   `ASSERT_IMPL(a_out_range, clock, reset, rsp_valid && !rsp_in_range,
      rsp_pixel_x == 0 && rsp_pixel_y == 0, "out-of-range result carries a pixel")

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chaos-game point iterator testbench
// Loads transform tables, starts points and iterates them under several
// register settings. A local fixed-point model predicts each finished pixel,
// and every returned pixel is checked in order against it. Both sides of the
// stream stall at random.
// ----------------------------------------------------------------------------
module tb import ifs_pkg::*; ();

   localparam logic [1:0] FuncUnused = 2'd3;
   localparam int Transforms = 8;

   typedef struct packed {
      logic [11:0] px;
      logic [11:0] py;
      logic        inr;
   } pixel_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [2:0]  req_entry_index;
   logic [3:0]  req_slot;
   logic signed [31:0] req_table_value;
   logic [15:0] req_point_x;
   logic [15:0] req_point_y;
   logic [15:0] req_chooser;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [11:0] rsp_pixel_x;
   logic [11:0] rsp_pixel_y;
   logic        rsp_in_range;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   // Model state of the iterator.
   logic signed [31:0] coef_q [Transforms*9];
   logic signed [31:0] prob_q [Transforms];
   logic signed [31:0] pos_x, pos_y, pos_z;
   logic [15:0] steps;
   logic [3:0]  cfg_count;
   logic [15:0] cfg_iters;
   logic [12:0] cfg_width, cfg_height;

   pixel_type pending_pixels[$];
   int errors;
   int sender_idle_pct, receiver_idle_pct;

   ifs_chaos_game_point_iterator DUT (.*);

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   initial begin
      #40ms;
      $display("[ifs_chaos_game_point_iterator] ERROR");
      $finish;
   end

   task automatic report(input string what);
      $display("mismatch: %s", what);
      errors++;
   endtask

   function automatic logic signed [31:0] mac_row(input int base);
      logic signed [65:0] acc;
      logic signed [65:0] shifted;
      acc = longint'(coef_q[base]) * longint'(pos_x);
      acc += longint'(coef_q[base+1]) * longint'(pos_y);
      acc += longint'(coef_q[base+2]) * longint'(pos_z);
      shifted = acc >>> 16;
      if (shifted > 66'sd2147483647) return 32'sh7fffffff;
      if (shifted < -66'sd2147483648) return 32'sh80000000;
      return shifted[31:0];
   endfunction

   function automatic logic scale_coord(input logic signed [31:0] c,
                                        input logic [12:0] size,
                                        output logic [11:0] pix);
      longint q;
      q = (longint'(c) * longint'(size)) / longint'(pos_z);
      pix = q[11:0];
      return !(q < 0 || q >= longint'(size) || q > 4095);
   endfunction

   // Applies one request to the model; returns 1 when a pixel is produced.
   function automatic logic iterate_point(input logic [1:0] func,
                                          input logic [2:0] entry,
                                          input logic [3:0] slot,
                                          input logic signed [31:0] value,
                                          input logic [15:0] px,
                                          input logic [15:0] py,
                                          input logic [15:0] ch,
                                          output pixel_type pix);
      int n, t;
      longint sum;
      logic signed [31:0] nx, ny, nz;
      logic ok;
      pix = '0;
      case (func)
         FuncLoad: begin
            if (slot == SlotProb) prob_q[entry] = value;
            else if (slot < SlotProb) coef_q[entry*9 + slot] = value;
            return 1'b0;
         end
         FuncStart: begin
            pos_x = {16'd0, px};
            pos_y = {16'd0, py};
            pos_z = OneQ16;
            steps = '0;
            return 1'b0;
         end
         FuncIterate: begin
            if (steps >= cfg_iters) return 1'b0;
            n = (cfg_count == 0) ? 1 : (cfg_count > Transforms ? Transforms : cfg_count);
            t = n - 1;
            sum = 0;
            for (int i = 0; i < n; i++) begin
               sum += prob_q[i];
               if (sum > longint'(ch)) begin
                  t = i;
                  break;
               end
            end
            nx = mac_row(t*9);
            ny = mac_row(t*9 + 3);
            nz = mac_row(t*9 + 6);
            pos_x = nx;
            pos_y = ny;
            pos_z = nz;
            steps = steps + 16'd1;
            if (steps != cfg_iters) return 1'b0;
            ok = pos_z != 0;
            if (ok) ok = scale_coord(pos_x, cfg_width, pix.px);
            if (ok) ok = scale_coord(pos_y, cfg_height, pix.py);
            if (!ok) begin
               pix.px = '0;
               pix.py = '0;
            end
            pix.inr = ok;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic send_request(input logic [1:0] func, input logic [2:0] entry,
                               input logic [3:0] slot, input logic signed [31:0] value,
                               input logic [15:0] px, input logic [15:0] py,
                               input logic [15:0] ch);
      pixel_type pix;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_func        <= func;
      req_entry_index <= entry;
      req_slot        <= slot;
      req_table_value <= value;
      req_point_x     <= px;
      req_point_y     <= py;
      req_chooser     <= ch;
      do @(posedge clock); while (req_stall);
      if (iterate_point(func, entry, slot, value, px, py, ch, pix))
         pending_pixels.push_back(pix);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      // An iterate without a pixel may still be in flight.
      repeat (200) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [15:0] data);
      drain();
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (index)
         CsrTransformCount: cfg_count  = data[3:0];
         CsrIterationCount: cfg_iters  = data;
         CsrImageWidth:     cfg_width  = data[12:0];
         default:           cfg_height = data[12:0];
      endcase
   endtask

   task automatic load_transform(input int idx, input logic wild);
      logic signed [31:0] c;
      for (int s = 0; s < 9; s++) begin
         if (wild) c = $urandom;
         else if (s == 2 || s == 5) c = $urandom_range(32768);
         else if (s == 6 || s == 7) c = 0;
         else if (s == 8) c = OneQ16;
         else c = $signed(32'($urandom_range(65536))) - 32768;
         send_request(FuncLoad, idx, s, c, $urandom, $urandom, $urandom);
      end
      send_request(FuncLoad, idx, SlotProb, wild ? $urandom : $urandom_range(16384),
                   $urandom, $urandom, $urandom);
   endtask

   // Returned pixels are compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            report("pixel with none expected");
         end else begin
            pixel_type want;
            want = pending_pixels.pop_front();
            if (rsp_pixel_x !== want.px)
               report($sformatf("pixel_x %0d, expected %0d", rsp_pixel_x, want.px));
            if (rsp_pixel_y !== want.py)
               report($sformatf("pixel_y %0d, expected %0d", rsp_pixel_y, want.py));
            if (rsp_in_range !== want.inr)
               report($sformatf("in_range %0b, expected %0b", rsp_in_range, want.inr));
         end
      end
      rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
   end

   task automatic test_table_load;
      for (int i = 0; i < Transforms; i++) load_transform(i, 1'b0);
      // Bad addresses and the unused code must leave the tables alone.
      for (int s = 10; s < 16; s++)
         send_request(FuncLoad, $urandom, s, $urandom, $urandom, $urandom, $urandom);
      send_request(FuncUnused, 3'd7, 4'd15, 32'hffffffff, 16'hffff, 16'hffff, 16'hffff);
   endtask

   task automatic test_directed;
      logic signed [31:0] big;
      big = 32'sh7fffffff;
      write_register(CsrTransformCount, 16'd8);
      write_register(CsrIterationCount, 16'd1);
      write_register(CsrImageWidth, 16'd4096);
      write_register(CsrImageHeight, 16'd4096);
      // Probabilities sum short of one, so a large chooser overruns the table.
      for (int i = 0; i < Transforms; i++)
         send_request(FuncLoad, i, SlotProb, 32'sd8000, 0, 0, 0);
      // Last transform has no z row; the one before saturates.
      for (int s = 6; s < 9; s++) send_request(FuncLoad, 3'd7, s, 32'sd0, 0, 0, 0);
      send_request(FuncLoad, 3'd6, 4'd0, big, 0, 0, 0);
      send_request(FuncLoad, 3'd6, 4'd4, -big - 1, 0, 0, 0);
      send_request(FuncStart, 0, 0, 0, 16'h0000, 16'h0000, 0);
      send_request(FuncIterate, 0, 0, 0, 0, 0, 16'h0000);
      send_request(FuncIterate, 0, 0, 0, 0, 0, 16'h0000);   // past the end
      send_request(FuncStart, 0, 0, 0, 16'hffff, 16'hffff, 0);
      send_request(FuncIterate, 0, 0, 0, 0, 0, 16'hffff);
      send_request(FuncStart, 0, 0, 0, 16'hffff, 16'h8000, 0);
      send_request(FuncIterate, 0, 0, 0, 0, 0, 16'd50000);
      write_register(CsrImageWidth, 16'd1);
      write_register(CsrImageHeight, 16'd1);
      send_request(FuncStart, 0, 0, 0, 16'h0001, 16'h0000, 0);
      send_request(FuncIterate, 0, 0, 0, 0, 0, 16'd100);
      write_register(CsrIterationCount, 16'd0);
      send_request(FuncStart, 0, 0, 0, 16'h1234, 16'h4321, 0);
      send_request(FuncIterate, 0, 0, 0, 0, 0, 16'd7);
      write_register(CsrIterationCount, 16'hffff);
      send_request(FuncStart, 0, 0, 0, 16'h1234, 16'h4321, 0);
      send_request(FuncIterate, 0, 0, 0, 0, 0, 16'd9);
      write_register(CsrTransformCount, 16'd0);
      write_register(CsrIterationCount, 16'd2);
      write_register(CsrImageWidth, 16'd8191);
      send_request(FuncStart, 0, 0, 0, 16'h4000, 16'h4000, 0);
      send_request(FuncIterate, 0, 0, 0, 0, 0, 16'd9);
      send_request(FuncIterate, 0, 0, 0, 0, 0, 16'hffff);
      write_register(CsrTransformCount, 16'd15);
      send_request(FuncStart, 0, 0, 0, 16'h4000, 16'h4000, 0);
      send_request(FuncIterate, 0, 0, 0, 0, 0, 16'hffff);
      send_request(FuncIterate, 0, 0, 0, 0, 0, 16'd20000);
   endtask

   task automatic test_random(input int sender_pct, input int receiver_pct);
      int budget, k;
      sender_idle_pct   = sender_pct;
      receiver_idle_pct = receiver_pct;
      write_register(CsrTransformCount, $urandom_range(15));
      write_register(CsrIterationCount, ($urandom_range(9) == 0) ? $urandom_range(8, 20)
                                                                  : $urandom_range(1, 4));
      write_register(CsrImageWidth, $urandom_range(1, 4096));
      write_register(CsrImageHeight, ($urandom_range(7) == 0) ? $urandom_range(8191)
                                                               : $urandom_range(1, 4096));
      budget = 190;
      while (budget > 0) begin
         k = $urandom_range(15);
         if (k == 0) begin
            load_transform($urandom_range(Transforms - 1), $urandom_range(5) == 0);
            budget -= 10;
         end else if (k == 1) begin
            send_request($urandom_range(1) ? FuncUnused : FuncLoad, $urandom,
                         $urandom_range(10, 15), $urandom, $urandom, $urandom, $urandom);
            budget--;
         end else begin
            send_request(FuncStart, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
            budget--;
            for (int i = 0; i < cfg_iters + ($urandom_range(4) == 0); i++) begin
               send_request(FuncIterate, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom);
               budget--;
            end
         end
      end
   endtask

   initial begin
      errors            = 0;
      sender_idle_pct   = 18;
      receiver_idle_pct = 77;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_func        <= FuncLoad;
      req_entry_index <= '0;
      req_slot        <= '0;
      req_table_value <= '0;
      req_point_x     <= '0;
      req_point_y     <= '0;
      req_chooser     <= '0;
      csr_write       <= 1'b0;
      csr_index       <= CsrTransformCount;
      csr_data        <= '0;
      pos_x = 0;
      pos_y = 0;
      pos_z = OneQ16;
      steps = 0;
      cfg_count  = 4'd1;
      cfg_iters  = 16'd1;
      cfg_width  = 13'd256;
      cfg_height = 13'd256;
      foreach (coef_q[i]) coef_q[i] = 0;
      foreach (prob_q[i]) prob_q[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_load();
      test_directed();
      test_random(18, 77);
      test_random(77, 18);
      test_random(0, 0);
      drain();
      if (errors == 0) begin
         $display("[ifs_chaos_game_point_iterator] OK");
      end else begin
         $display("[ifs_chaos_game_point_iterator] ERROR");
      end
      $finish;
   end
endmodule

// File: ifs_chaos_game_point_iterator.f
+incdir+rtl
rtl/ifs_pkg.sv
rtl/ifs_coef_mem.sv
rtl/ifs_divider.sv
rtl/ifs_chaos_game_point_iterator.sv
test/tb.sv
